// ----- sv/ebpr_pkg.sv -----
package ebpr_pkg;

   localparam int ACTION_W = 2;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int AMOUNT_W = 16;
   localparam int ACC_W    = 16;
   localparam int BYTE_W   = 8;
   localparam int SIZE_W   = 9;
   localparam int PHASE_W  = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_STORE   = 2'd0,
      ACT_READ    = 2'd1,
      ACT_DISCARD = 2'd2,
      ACT_FLUSH   = 2'd3
   } act_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SRD,
      ST_SWR,
      ST_RRD,
      ST_POP,
      ST_DISC,
      ST_FLUSH,
      ST_DONE
   } st_type;

   // request to the ring pointer adder
   typedef struct packed {
      logic [SIZE_W-1:0] base;
      logic [SIZE_W-1:0] step;
      logic [SIZE_W-1:0] size;
   } ring_op_type;

endpackage

// ----- sv/ebpr_ifs.sv -----
interface ebpr_req_if;
   import ebpr_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [WORD_W-1:0]   word;
   logic [COUNT_W-1:0]  bit_count;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, output action, output word, output bit_count,
                   output amount, input ready);
   modport sink   (input valid, input action, input word, input bit_count,
                   input amount, output ready);
endinterface

interface ebpr_rsp_if;
   import ebpr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACC_W-1:0]  accepted;
   logic [BYTE_W-1:0] byte_out;
   logic [SIZE_W-1:0] used_bytes;
   logic              is_full;

   modport source (output valid, output accepted, output byte_out,
                   output used_bytes, output is_full, input ready);
   modport sink   (input valid, input accepted, input byte_out,
                   input used_bytes, input is_full, output ready);
endinterface

interface ebpr_csr_if;
   import ebpr_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ebpr_ram.sv -----
module ebpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/ebpr_ring_alu.sv -----
module ebpr_ring_alu (
   input  ebpr_pkg::ring_op_type           op,
   output logic [ebpr_pkg::SIZE_W-1:0]     res
);
   import ebpr_pkg::*;

   logic [SIZE_W:0] sum;
   logic [SIZE_W:0] size_x;
   logic [SIZE_W:0] wrapped;

   always_comb begin
      size_x  = {1'b0, op.size};
      sum     = {1'b0, op.base} + {1'b0, op.step};
      wrapped = sum;
      if (sum >= size_x) begin
         wrapped = sum - size_x;
      end
      if (wrapped >= size_x) begin
         wrapped = '0;
      end
      res = wrapped[SIZE_W-1:0];
   end

endmodule

// ----- sv/ebpr_ctrl.sv -----
module ebpr_ctrl #(
   parameter int DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   ebpr_req_if.sink                            req,
   ebpr_rsp_if.source                          rsp,
   ebpr_csr_if.sink                            csr,
   output ebpr_pkg::ring_op_type               alu_op,
   input  logic [ebpr_pkg::SIZE_W-1:0]         alu_res,
   output logic                                mem_we,
   output logic [$clog2(DEPTH)-1:0]            mem_waddr,
   output logic [ebpr_pkg::BYTE_W-1:0]         mem_wdata,
   output logic [$clog2(DEPTH)-1:0]            mem_raddr,
   input  logic [ebpr_pkg::BYTE_W-1:0]         mem_rdata
);
   import ebpr_pkg::*;

   localparam int IW       = $clog2(DEPTH);
   localparam int RST_SIZE = (DEPTH < 256) ? DEPTH : 256;

   st_type              state_ff, state_in;
   logic [IW-1:0]       clr_ff, clr_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic                full_ff, full_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [4:0]          rem_ff, rem_in;
   logic [AMOUNT_W-1:0] amount_ff, amount_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]    o_acc_ff, o_acc_in;
   logic [BYTE_W-1:0]   o_byte_ff, o_byte_in;
   logic [SIZE_W-1:0]   o_used_ff, o_used_in;
   logic                o_full_ff, o_full_in;

   logic [SIZE_W-1:0]   head9, tail9, used9, amt9, csr_size;
   logic [3:0]          room, k, psum;
   logic                wrap;
   logic [BYTE_W-1:0]   lowmask, mask;
   logic [15:0]         mask16;
   act_type             req_act;

   assign req_act = act_type'(req.action);
   assign head9   = SIZE_W'(head_ff);
   assign tail9   = SIZE_W'(tail_ff);

   // bytes held, from the pointers
   always_comb begin
      if (head_ff == tail_ff && !full_ff) begin
         used9 = '0;
      end else if (tail9 > head9) begin
         used9 = tail9 - head9;
      end else begin
         used9 = size_ff - (head9 - tail9);
      end
      if ({7'd0, used9} < amount_ff) begin
         amt9 = used9;
      end else begin
         amt9 = amount_ff[SIZE_W-1:0];
      end
   end

   // one chunk of a store: bits up to the end of the current byte
   always_comb begin
      room = 4'd8 - {1'b0, phase_ff};
      if ({1'b0, room} < rem_ff) begin
         k = room;
      end else begin
         k = rem_ff[3:0];
      end
      lowmask = BYTE_W'((9'd1 << k) - 9'd1);
      mask16  = {8'd0, word_ff[7:0] & lowmask} << phase_ff;
      mask    = mask16[7:0];
      psum    = {1'b0, phase_ff} + k;
      wrap    = (psum == 4'd8);
   end

   always_comb begin
      csr_size = csr.data;
      if (csr.data == '0) begin
         csr_size = SIZE_W'(1);
      end else if ({8'd0, csr.data} > 17'(DEPTH)) begin
         csr_size = SIZE_W'(DEPTH);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               case (req_act)
                  ACT_STORE:   state_in = ST_SRD;
                  ACT_READ:    state_in = ST_RRD;
                  ACT_DISCARD: state_in = ST_DISC;
                  ACT_FLUSH:   state_in = ST_FLUSH;
                  default:     state_in = ST_FLUSH;
               endcase
            end
         end
         ST_SRD: begin
            state_in = (rem_ff == '0) ? ST_DONE : ST_SWR;
         end
         ST_SWR:   state_in = ST_SRD;
         ST_RRD: begin
            state_in = (used9 == '0) ? ST_DONE : ST_POP;
         end
         ST_POP:   state_in = ST_DONE;
         ST_DISC:  state_in = ST_DONE;
         ST_FLUSH: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.accepted   = o_acc_ff;
   assign rsp.byte_out   = o_byte_ff;
   assign rsp.used_bytes = o_used_ff;
   assign rsp.is_full    = o_full_ff;

   // outputs and register updates
   always_comb begin
      clr_in       = clr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      full_in      = full_ff;
      phase_in     = phase_ff;
      size_in      = size_ff;
      word_in      = word_ff;
      rem_in       = rem_ff;
      amount_in    = amount_ff;
      acc_in       = acc_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      o_acc_in     = o_acc_ff;
      o_byte_in    = o_byte_ff;
      o_used_in    = o_used_ff;
      o_full_in    = o_full_ff;
      alu_op.base  = tail9;
      alu_op.step  = SIZE_W'(1);
      alu_op.size  = size_ff;
      mem_we       = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = mem_rdata ^ mask;
      mem_raddr    = tail_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = IW'(clr_ff + 1'b1);
         end
         ST_IDLE: begin
            if (req.valid) begin
               word_in   = req.word;
               rem_in    = req.bit_count[4:0];
               amount_in = req.amount;
               acc_in    = (req_act == ACT_STORE) ? ACC_W'(req.bit_count[4:0]) : '0;
               byte_in   = '0;
            end
         end
         ST_SWR: begin
            mem_we   = 1'b1;
            phase_in = psum[PHASE_W-1:0];
            word_in  = word_ff >> k;
            rem_in   = rem_ff - {1'b0, k};
            if (wrap) begin
               // full means head equals tail, so one advance serves both
               tail_in = IW'(alu_res);
               if (full_ff) begin
                  head_in = IW'(alu_res);
               end
               full_in = full_ff || (IW'(alu_res) == head_ff);
            end
         end
         ST_RRD: begin
            mem_raddr = head_ff;
         end
         ST_POP: begin
            alu_op.base = head9;
            byte_in     = mem_rdata;
            head_in     = IW'(alu_res);
            full_in     = 1'b0;
            acc_in      = ACC_W'(1);
         end
         ST_DISC: begin
            alu_op.base = head9;
            alu_op.step = amt9;
            head_in     = IW'(alu_res);
            if (amt9 != '0) begin
               full_in = 1'b0;
            end
            acc_in      = ACC_W'(amt9);
         end
         ST_FLUSH: begin
            head_in = '0;
            tail_in = '0;
            full_in = 1'b0;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               o_acc_in     = acc_ff;
               o_byte_in    = byte_ff;
               o_used_in    = used9;
               o_full_in    = (used9 == size_ff);
            end
         end
         default: begin
         end
      endcase
      if (csr.valid) begin
         size_in  = csr_size;
         head_in  = '0;
         tail_in  = '0;
         full_in  = 1'b0;
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b0;
         phase_ff     <= '0;
         size_ff      <= SIZE_W'(RST_SIZE);
         word_ff      <= '0;
         rem_ff       <= '0;
         amount_ff    <= '0;
         acc_ff       <= '0;
         byte_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         o_acc_ff     <= '0;
         o_byte_ff    <= '0;
         o_used_ff    <= '0;
         o_full_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         phase_ff     <= phase_in;
         size_ff      <= size_in;
         word_ff      <= word_in;
         rem_ff       <= rem_in;
         amount_ff    <= amount_in;
         acc_ff       <= acc_in;
         byte_ff      <= byte_in;
         rsp_valid_ff <= rsp_valid_in;
         o_acc_ff     <= o_acc_in;
         o_byte_ff    <= o_byte_in;
         o_used_ff    <= o_used_in;
         o_full_ff    <= o_full_in;
      end
   end

endmodule

// ----- sv/entropy_bit_pool_ring.sv -----
// channel  | dir | fields                                  | accepted when
// req_chan | in  | action, word, bit_count, amount         | valid && ready
// rsp_chan | out | accepted, byte_out, used_bytes, is_full | valid && ready
// csr_chan | in  | data (pool_size)                        | valid && ready
//
// Store: each pool byte touched is read, then written back XORed in the byte
// memory. One result word per request, held in an output register until
// taken; a request finishing while it is still held waits in its last cycle.
// After reset the byte memory is swept to zero, all DEPTH bytes, one byte a
// cycle; req_chan stays not ready meanwhile. csr_chan is always ready.
module entropy_bit_pool_ring #(
   parameter int DEPTH = 256
) (
   input logic         clock,
   input logic         reset,
   ebpr_req_if.sink    req_chan,
   ebpr_rsp_if.source  rsp_chan,
   ebpr_csr_if.sink    csr_chan
);
   import ebpr_pkg::*;

   localparam int IW = $clog2(DEPTH);

   ring_op_type        alu_op;
   logic [SIZE_W-1:0]  alu_res;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   logic [BYTE_W-1:0]  mem_wdata;
   logic [IW-1:0]      mem_raddr;
   logic [BYTE_W-1:0]  mem_rdata;

   ebpr_ctrl #(.DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr       (csr_chan),
      .alu_op    (alu_op),
      .alu_res   (alu_res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   ebpr_ring_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   ebpr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_pool (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import ebpr_pkg::*;

   localparam int RING_DEPTH = 256;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      logic [ACC_W-1:0]  accepted;
      logic [BYTE_W-1:0] byte_out;
      logic [SIZE_W-1:0] used_bytes;
      logic              is_full;
   } pool_status_type;

   logic clock;
   logic reset;

   ebpr_req_if req_if ();
   ebpr_rsp_if rsp_if ();
   ebpr_csr_if csr_if ();

   entropy_bit_pool_ring #(.DEPTH(RING_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // shadow of the pool
   logic [BYTE_W-1:0]  pool_mem [RING_DEPTH];
   int                 head_idx;
   int                 tail_idx;
   int                 pool_len;
   bit                 ring_full;
   logic [PHASE_W-1:0] bit_phase;

   pool_status_type pending_status [$];
   bit           idle_on;
   int           mismatches;
   int           words_sent;
   int           words_checked;
   int           size_writes;

   always #10 clock = ~clock;

   function automatic int ring_step(int idx, int step);
      int v;
      v = idx + step;
      if (v >= pool_len) v -= pool_len;
      if (v >= pool_len) v = 0;
      return v;
   endfunction

   function automatic int bytes_held();
      if (head_idx == tail_idx && !ring_full) return 0;
      if (tail_idx > head_idx) return tail_idx - head_idx;
      return pool_len - (head_idx - tail_idx);
   endfunction

   function automatic pool_status_type pool_predict(act_type act, logic [WORD_W-1:0] w,
                                                    logic [COUNT_W-1:0] cnt,
                                                    logic [AMOUNT_W-1:0] amt);
      pool_status_type r;
      int           nbits;
      int           take;
      int           held;
      r = '0;
      case (act)
         ACT_STORE: begin
            nbits = cnt[4:0];
            r.accepted = ACC_W'(nbits);
            for (int i = 0; i < nbits; i++) begin
               pool_mem[tail_idx][bit_phase] = pool_mem[tail_idx][bit_phase] ^ w[i];
               bit_phase = bit_phase + 1'b1;
               if (bit_phase == 0) begin
                  // a full ring drops its oldest byte as the tail moves on
                  if (ring_full) head_idx = ring_step(head_idx, 1);
                  tail_idx = ring_step(tail_idx, 1);
                  ring_full = (tail_idx == head_idx);
               end
            end
         end
         ACT_READ: begin
            if (bytes_held() != 0) begin
               r.byte_out = pool_mem[head_idx];
               head_idx = ring_step(head_idx, 1);
               ring_full = 1'b0;
               r.accepted = ACC_W'(1);
            end
         end
         ACT_DISCARD: begin
            take = amt;
            held = bytes_held();
            if (take > held) take = held;
            head_idx = ring_step(head_idx, take);
            if (take > 0) ring_full = 1'b0;
            r.accepted = ACC_W'(take);
         end
         default: begin
            head_idx = 0;
            tail_idx = 0;
            ring_full = 1'b0;
         end
      endcase
      held = bytes_held();
      r.used_bytes = SIZE_W'(held);
      r.is_full = (held == pool_len);
      return r;
   endfunction

   task automatic send_item(act_type act, logic [WORD_W-1:0] w, logic [COUNT_W-1:0] cnt,
                            logic [AMOUNT_W-1:0] amt);
      int gap;
      gap = idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.action    <= act;
      req_if.word      <= w;
      req_if.bit_count <= cnt;
      req_if.amount    <= amt;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      pending_status.push_back(pool_predict(act, w, cnt, amt));
      words_sent++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called with the ring idle
   task automatic write_pool_size(logic [SIZE_W-1:0] v);
      csr_if.valid <= 1'b1;
      csr_if.data  <= v;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      pool_len  = (v == 0) ? 1 : (v > RING_DEPTH) ? RING_DEPTH : int'(v);
      head_idx  = 0;
      tail_idx  = 0;
      ring_full = 1'b0;
      bit_phase = '0;
      size_writes++;
   endtask

   task automatic test_reset_defaults();
      idle_on = 1'b0;
      send_item(ACT_READ, '0, '0, '0);                  // read when empty
      send_item(ACT_DISCARD, '0, '0, 16'd5);            // discard when empty
      send_item(ACT_STORE, 32'hFFFF_FFFF, 8'd0, '0);    // zero bits
      send_item(ACT_STORE, 32'hFFFF_FFFF, 8'd32, '0);   // count wraps to zero
      send_item(ACT_STORE, 32'hFFFF_FFFF, 8'd255, '0);  // 31 bits
      send_item(ACT_STORE, 32'hA5A5_A5A5, 8'd8, '0);
      send_item(ACT_READ, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      send_item(ACT_DISCARD, 32'hFFFF_FFFF, 8'hFF, 16'd0);
      send_item(ACT_DISCARD, '0, '0, 16'hFFFF);
      send_item(ACT_FLUSH, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      // phase survives the flush
      send_item(ACT_STORE, 32'h0000_0001, 8'd1, '0);
      send_item(ACT_READ, '0, '0, '0);
   endtask

   task automatic test_size_limits();
      idle_on = 1'b1;
      settle();
      write_pool_size('0);                              // zero taken as one
      send_item(ACT_STORE, 32'h0000_00FF, 8'd8, '0);
      send_item(ACT_STORE, 32'h0000_000F, 8'd8, '0);    // stores while full
      send_item(ACT_READ, '0, '0, '0);
      send_item(ACT_STORE, 32'h0000_F00F, 8'd16, '0);
      send_item(ACT_DISCARD, '0, '0, 16'hFFFF);
      send_item(ACT_FLUSH, '0, '0, '0);
      settle();
      write_pool_size(9'd511);                          // saturates to depth
      send_item(ACT_STORE, 32'hFFFF_FFFF, 8'd31, '0);
      send_item(ACT_READ, '0, '0, '0);
      settle();
      write_pool_size(9'd2);
      send_item(ACT_STORE, 32'hDEAD_BEEF, 8'd24, '0);
      send_item(ACT_DISCARD, '0, '0, 16'd1);
      send_item(ACT_READ, '0, '0, '0);
      send_item(ACT_READ, '0, '0, '0);
   endtask

   task automatic test_random_traffic(logic [SIZE_W-1:0] size_word, int n_items,
                                      int store_wt);
      int      pick;
      int      rest;
      act_type act;
      logic [AMOUNT_W-1:0] amt;
      settle();
      write_pool_size(size_word);
      rest = 100 - store_wt;
      for (int k = 0; k < n_items; k++) begin
         if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 99);
         if (pick < store_wt) act = ACT_STORE;
         else if (pick < store_wt + rest / 2) act = ACT_READ;
         else if (pick < store_wt + rest * 9 / 10) act = ACT_DISCARD;
         else act = ACT_FLUSH;
         if ($urandom_range(0, 2) != 0) amt = AMOUNT_W'($urandom_range(0, bytes_held() + 2));
         else amt = AMOUNT_W'($urandom_range(0, 65535));
         send_item(act, $urandom, COUNT_W'($urandom_range(0, 255)), amt);
      end
   endtask

   task automatic report_field(string name, int want, int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
   endtask

   // result checker
   always @(posedge clock) begin
      pool_status_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         words_checked++;
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: result word with none pending", $realtime);
         end else begin
            want = pending_status.pop_front();
            if (rsp_if.accepted !== want.accepted)
               report_field("accepted", want.accepted, rsp_if.accepted);
            if (rsp_if.byte_out !== want.byte_out)
               report_field("byte_out", want.byte_out, rsp_if.byte_out);
            if (rsp_if.used_bytes !== want.used_bytes)
               report_field("used_bytes", want.used_bytes, rsp_if.used_bytes);
            if (rsp_if.is_full !== want.is_full)
               report_field("is_full", want.is_full, rsp_if.is_full);
         end
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      rsp_if.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         stall = idle_on ? $urandom_range(0, 18) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      #10ms;
      $display("timeout with %0d result words outstanding", pending_status.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.action    <= ACT_STORE;
      req_if.word      <= '0;
      req_if.bit_count <= '0;
      req_if.amount    <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.data      <= '0;
      for (int i = 0; i < RING_DEPTH; i++) pool_mem[i] = '0;
      head_idx = 0;
      tail_idx = 0;
      ring_full = 1'b0;
      bit_phase = '0;
      pool_len = RING_DEPTH;
      idle_on = 1'b0;
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      size_writes = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_size_limits();
      test_random_traffic(9'd1, 80, 50);
      test_random_traffic(9'd3, 80, 50);
      test_random_traffic(SIZE_W'($urandom_range(4, 20)), 100, 55);
      test_random_traffic(9'd256, 200, 90);             // store heavy, fills the ring
      test_random_traffic(9'd511, 50, 60);
      test_random_traffic(SIZE_W'($urandom_range(0, 511)), 50, 60);
      test_random_traffic(9'd2, 40, 50);
      settle();

      if (pending_status.size() != 0) mismatches++;
      $display("ring checked over %0d pool size writes: %0d words sent, %0d results compared",
               size_writes, words_sent, words_checked);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/ebpr_pkg.sv
sv/ebpr_ifs.sv
sv/ebpr_ram.sv
sv/ebpr_ring_alu.sv
sv/ebpr_ctrl.sv
sv/entropy_bit_pool_ring.sv
bench/tb.sv
